// File: rtl/ffba_pkg.sv
// Shared constants and types for the first-fit block allocator.
package ffba_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int OFF_W       = 32;

	localparam logic [OFF_W-1:0] POOL_RESET = OFF_W'(1048576);

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic             free;
		logic [OFF_W-1:0] block_width;
		logic [OFF_W-1:0] used_width;
		logic [OFF_W-1:0] offset;
	} entry_t;

endpackage

// File: rtl/ffba_if.sv
// Request and response channel interfaces of the allocator.
interface ffba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [ffba_pkg::OFF_W-1:0]  request_bytes;
	logic [ffba_pkg::OFF_W-1:0]  release_offset;

	modport source (output valid, req_type, request_bytes, release_offset, input ready);
	modport sink   (input valid, req_type, request_bytes, release_offset, output ready);
endinterface

interface ffba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [ffba_pkg::OFF_W-1:0]  granted_offset;

	modport source (output valid, status, granted_offset, input ready);
	modport sink   (input valid, status, granted_offset, output ready);
endinterface

// File: rtl/first_fit_block_allocator.sv
// First-fit block allocator: entry table in one synchronous RAM, scan and update FSM.
//
// Channels: req takes one word per request (req_type 0 allocate request_bytes,
// 1 free release_offset); rsp returns one word per request with status and
// granted_offset. Both use valid/ready; a word moves when both are high.
// cfg_we/cfg_wdata write pool_size; write only while the block is idle.
//
// Timing: one request is in work at a time. The scan walks the entries one
// per cycle through the single registered read port of the table RAM, then
// sees the end. A new entry costs a write in S_ADD, and S_FIN loads the
// response into the output register; the next request is taken once the
// FSM is back in S_IDLE.
//
// Reset: entry count and fill pointer clear, pool_size returns to 1 MiB.
// The table RAM itself is not cleared; only entries below the count are read.
//
// Stall: the response sits in an output register; a new request is taken
// while it waits. A finished request holds in its last state until the
// output register is free.
module first_fit_block_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	ffba_req_if.sink                   req,
	ffba_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [ffba_pkg::OFF_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ADD, S_FIN} state_t;

	state_t                      state_q;
	ffba_pkg::entry_t            tbl_q [ffba_pkg::MAX_ENTRIES];
	ffba_pkg::entry_t            rd_data_s1;
	logic                        rd_vld_s1;
	logic [ffba_pkg::CNT_W-1:0]  idx_s1;
	logic [ffba_pkg::CNT_W-1:0]  issue_q;
	logic [ffba_pkg::CNT_W-1:0]  count_q;
	logic [ffba_pkg::OFF_W-1:0]  fill_q;
	logic [ffba_pkg::OFF_W-1:0]  pool_q;
	logic                        kind_q;
	logic [ffba_pkg::OFF_W-1:0]  size_q;
	logic [ffba_pkg::OFF_W-1:0]  roff_q;
	ffba_pkg::entry_t            add_q;
	ffba_pkg::status_t           res_status_q;
	logic [ffba_pkg::OFF_W-1:0]  res_off_q;
	logic                        rsp_valid_q;
	ffba_pkg::status_t           rsp_status_q;
	logic [ffba_pkg::OFF_W-1:0]  rsp_off_q;

	logic                        mem_we;
	logic [ffba_pkg::IDX_W-1:0]  mem_wa;
	ffba_pkg::entry_t            mem_wd;

	logic                        in_scan;
	logic                        is_alloc;
	logic                        tbl_full;
	logic [ffba_pkg::OFF_W-1:0]  slack;
	logic                        hit_reuse;
	logic                        hit_split;
	logic                        hit_free;
	logic                        scan_done;
	logic                        fp_ge;
	logic                        bump_over;
	logic [ffba_pkg::OFF_W:0]    bump_sum;
	logic [ffba_pkg::OFF_W-1:0]  split_off;

	assign in_scan   = (state_q == S_SCAN) && rd_vld_s1;
	assign is_alloc  = (kind_q == ffba_pkg::REQ_ALLOC);
	assign tbl_full  = (count_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_ENTRIES));
	assign slack     = rd_data_s1.block_width - rd_data_s1.used_width;
	assign hit_reuse = in_scan && is_alloc && rd_data_s1.free
		&& (rd_data_s1.block_width >= size_q);
	assign hit_split = in_scan && is_alloc && !hit_reuse
		&& (rd_data_s1.used_width <= rd_data_s1.block_width) && (slack >= size_q);
	assign hit_free  = in_scan && !is_alloc && (rd_data_s1.offset == roff_q);
	assign scan_done = (state_q == S_SCAN) && !rd_vld_s1 && (issue_q == count_q);
	assign split_off = rd_data_s1.offset + rd_data_s1.used_width;
	assign fp_ge     = (fill_q >= pool_q);
	assign bump_sum  = {1'b0, fill_q} + {1'b0, size_q};
	assign bump_over = (bump_sum > {1'b0, pool_q});

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1[ffba_pkg::IDX_W-1:0];
		mem_wd = rd_data_s1;
		if (hit_reuse) begin
			mem_we            = 1'b1;
			mem_wd.free       = 1'b0;
			mem_wd.used_width = size_q;
		end else if (hit_split && !tbl_full) begin
			mem_we             = 1'b1;
			mem_wd.block_width = rd_data_s1.used_width;
		end else if (hit_free) begin
			mem_we            = 1'b1;
			mem_wd.free       = 1'b1;
			mem_wd.used_width = '0;
		end else if (state_q == S_ADD) begin
			mem_we = 1'b1;
			mem_wa = count_q[ffba_pkg::IDX_W-1:0];
			mem_wd = add_q;
		end
	end

	// table RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_q[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= tbl_q[issue_q[ffba_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			issue_q      <= '0;
			count_q      <= '0;
			fill_q       <= '0;
			pool_q       <= ffba_pkg::POOL_RESET;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ffba_pkg::ST_OK;
			rsp_off_q    <= '0;
			kind_q       <= 1'b0;
			size_q       <= '0;
			roff_q       <= '0;
			add_q        <= '0;
			res_status_q <= ffba_pkg::ST_OK;
			res_off_q    <= '0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					issue_q   <= '0;
					if (req.valid) begin
						kind_q  <= req.req_type;
						size_q  <= req.request_bytes;
						roff_q  <= req.release_offset;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q != count_q) begin
						rd_vld_s1 <= 1'b1;
						idx_s1    <= issue_q;
						issue_q   <= issue_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (hit_reuse) begin
						res_status_q <= ffba_pkg::ST_OK;
						res_off_q    <= rd_data_s1.offset;
						state_q      <= S_FIN;
					end else if (hit_split) begin
						if (tbl_full) begin
							res_status_q <= ffba_pkg::ST_TABLE_FULL;
							res_off_q    <= '0;
							state_q      <= S_FIN;
						end else begin
							add_q        <= '{free: 1'b0, block_width: slack,
								used_width: size_q, offset: split_off};
							res_status_q <= ffba_pkg::ST_OK;
							res_off_q    <= split_off;
							state_q      <= S_ADD;
						end
					end else if (hit_free) begin
						res_status_q <= ffba_pkg::ST_OK;
						res_off_q    <= '0;
						state_q      <= S_FIN;
					end else if (scan_done) begin
						if (!is_alloc) begin
							res_status_q <= ffba_pkg::ST_NOT_FOUND;
							res_off_q    <= '0;
							state_q      <= S_FIN;
						end else if (fp_ge || bump_over) begin
							res_status_q <= ffba_pkg::ST_EXHAUSTED;
							res_off_q    <= '0;
							state_q      <= S_FIN;
						end else if (tbl_full) begin
							res_status_q <= ffba_pkg::ST_TABLE_FULL;
							res_off_q    <= '0;
							state_q      <= S_FIN;
						end else begin
							add_q        <= '{free: 1'b0, block_width: size_q,
								used_width: size_q, offset: fill_q};
							fill_q       <= bump_sum[ffba_pkg::OFF_W-1:0];
							res_status_q <= ffba_pkg::ST_OK;
							res_off_q    <= fill_q;
							state_q      <= S_ADD;
						end
					end
				end
				S_ADD: begin
					rd_vld_s1 <= 1'b0;
					count_q   <= count_q + 1'b1;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					rd_vld_s1 <= 1'b0;
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_off_q    <= res_off_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.granted_offset = rsp_off_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_wa} < count_q || (state_q == S_ADD && !tbl_full)))
		else $error("table write outside live entries");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && state_q == S_SCAN |-> idx_s1 < count_q)
		else $error("scan reads beyond entry count");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ffba_pkg::ST_OK |-> rsp.granted_offset == '0)
		else $error("nonzero offset on failed request");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |=> count_q == $past(count_q) + 1'b1)
		else $error("new entry did not advance count");

endmodule

// File: tb/ffba_checker.sv
`timescale 1ns / 1ps
// Checker for the first-fit block allocator: tracks the block table and compares every reply word.
module ffba_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	ffba_req_if                        req,
	ffba_rsp_if                        rsp,
	input  logic                       cfg_we,
	input  logic [ffba_pkg::OFF_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending
);

	localparam logic [ffba_pkg::OFF_W-1:0] NO_OFFSET = '0;

	typedef struct packed {
		ffba_pkg::status_t          status;
		logic [ffba_pkg::OFF_W-1:0] offset;
	} reply_t;

	logic                       blk_free  [ffba_pkg::MAX_ENTRIES];
	logic [ffba_pkg::OFF_W-1:0] blk_width [ffba_pkg::MAX_ENTRIES];
	logic [ffba_pkg::OFF_W-1:0] blk_used  [ffba_pkg::MAX_ENTRIES];
	logic [ffba_pkg::OFF_W-1:0] blk_base  [ffba_pkg::MAX_ENTRIES];
	int                         blk_count;
	logic [ffba_pkg::OFF_W-1:0] fill_ptr;
	logic [ffba_pkg::OFF_W-1:0] pool_bytes;
	reply_t                     expected_replies [$];
	int                         reply_num;

	function automatic void add_block(logic [ffba_pkg::OFF_W-1:0] width,
			logic [ffba_pkg::OFF_W-1:0] used, logic [ffba_pkg::OFF_W-1:0] base);
		blk_free[blk_count]  = 1'b0;
		blk_width[blk_count] = width;
		blk_used[blk_count]  = used;
		blk_base[blk_count]  = base;
		blk_count++;
	endfunction

	function automatic reply_t allocate_reply(logic [ffba_pkg::OFF_W-1:0] size);
		logic [ffba_pkg::OFF_W:0] bump_end;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_width[i] >= size) begin
				blk_free[i] = 1'b0;
				blk_used[i] = size;
				return reply_t'{ffba_pkg::ST_OK, blk_base[i]};
			end
			if (blk_used[i] <= blk_width[i] && blk_width[i] - blk_used[i] >= size) begin
				if (blk_count >= ffba_pkg::MAX_ENTRIES)
					return reply_t'{ffba_pkg::ST_TABLE_FULL, NO_OFFSET};
				add_block(blk_width[i] - blk_used[i], size, blk_base[i] + blk_used[i]);
				blk_width[i] = blk_used[i];
				return reply_t'{ffba_pkg::ST_OK, blk_base[blk_count-1]};
			end
		end
		bump_end = {1'b0, fill_ptr} + {1'b0, size};
		if (fill_ptr >= pool_bytes || bump_end > {1'b0, pool_bytes})
			return reply_t'{ffba_pkg::ST_EXHAUSTED, NO_OFFSET};
		if (blk_count >= ffba_pkg::MAX_ENTRIES)
			return reply_t'{ffba_pkg::ST_TABLE_FULL, NO_OFFSET};
		add_block(size, size, fill_ptr);
		fill_ptr = bump_end[ffba_pkg::OFF_W-1:0];
		return reply_t'{ffba_pkg::ST_OK, blk_base[blk_count-1]};
	endfunction

	function automatic reply_t release_reply(logic [ffba_pkg::OFF_W-1:0] base);
		for (int i = 0; i < blk_count; i++) begin
			if (blk_base[i] == base) begin
				blk_free[i] = 1'b1;
				blk_used[i] = '0;
				return reply_t'{ffba_pkg::ST_OK, NO_OFFSET};
			end
		end
		return reply_t'{ffba_pkg::ST_NOT_FOUND, NO_OFFSET};
	endfunction

	task automatic flag(string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			blk_count  = 0;
			fill_ptr   = '0;
			pool_bytes = ffba_pkg::POOL_RESET;
			expected_replies.delete();
			reply_num  = 0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					flag($sformatf("reply %0d unexpected: status %0d offset %h",
						reply_num, rsp.status, rsp.granted_offset));
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status || rsp.granted_offset !== want.offset)
						flag($sformatf({"reply %0d: expected status %0d offset %h, ",
							"got status %0d offset %h"},
							reply_num, want.status, want.offset,
							rsp.status, rsp.granted_offset));
				end
				reply_num++;
			end
			if (cfg_we)
				pool_bytes = cfg_wdata;
			if (req.valid && req.ready) begin
				if (ffba_pkg::req_kind_t'(req.req_type) == ffba_pkg::REQ_ALLOC)
					expected_replies.push_back(allocate_reply(req.request_bytes));
				else
					expected_replies.push_back(release_reply(req.release_offset));
			end
			pending = expected_replies.size();
		end
	end

endmodule

// File: tb/first_fit_block_allocator_test.sv
`timescale 1ns / 1ps
// Testbench top: drives allocate/free words and pool_size writes, then reports the verdict.
module first_fit_block_allocator_test;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [ffba_pkg::OFF_W-1:0] cfg_wdata = '0;

	ffba_req_if req ();
	ffba_rsp_if rsp ();

	int                         fail_count;
	int                         pending;
	int                         sent       = 0;
	int                         received   = 0;
	int                         send_idle  = 0;
	int                         recv_stall = 0;
	ffba_pkg::status_t          last_status = ffba_pkg::ST_OK;
	logic [ffba_pkg::OFF_W-1:0] granted_log [$];

	first_fit_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ffba_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall);

	// remember granted offsets so frees mostly hit live blocks
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			received++;
			last_status = ffba_pkg::status_t'(rsp.status);
			if (last_status == ffba_pkg::ST_OK && rsp.granted_offset != '0)
				granted_log.push_back(rsp.granted_offset);
			if (granted_log.size() > 512)
				void'(granted_log.pop_front());
		end
	end

	task automatic send_word(ffba_pkg::req_kind_t kind, logic [ffba_pkg::OFF_W-1:0] bytes,
			logic [ffba_pkg::OFF_W-1:0] offset);
		if ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		req.valid          <= 1'b1;
		req.req_type       <= kind;
		req.request_bytes  <= bytes;
		req.release_offset <= offset;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_replies();
		req.valid <= 1'b0;
		@(posedge clk);
		while (received != sent)
			@(posedge clk);
	endtask

	task automatic write_pool(logic [ffba_pkg::OFF_W-1:0] value);
		wait_replies();
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// narrow: keep sizes at or below 1 MiB so the fill pointer stays low
	task automatic random_item(bit narrow);
		logic [ffba_pkg::OFF_W-1:0] bytes;
		logic [ffba_pkg::OFF_W-1:0] offset;
		bytes  = $urandom;
		offset = $urandom;
		if ($urandom_range(99) < 35) begin
			if (granted_log.size() > 0 && $urandom_range(3) != 0) begin
				offset = granted_log[$urandom_range(granted_log.size() - 1)];
				if ($urandom_range(9) == 0)
					offset = offset + 1;
			end
			send_word(ffba_pkg::REQ_FREE, bytes, offset);
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3: bytes = $urandom_range(64);
				4, 5:       bytes = $urandom_range(4096);
				6:          bytes = $urandom_range(65536);
				7:          bytes = $urandom_range(1 << 20);
				8:          bytes = '0;
				default: begin
					if (narrow)
						bytes = $urandom_range(1 << 20);
				end
			endcase
			send_word(ffba_pkg::REQ_ALLOC, bytes, offset);
		end
		if ($urandom_range(39) == 0)
			wait_replies();
	endtask

	initial begin
		req.valid          = 1'b0;
		req.req_type       = ffba_pkg::REQ_ALLOC;
		req.request_bytes  = '0;
		req.release_offset = '0;
		rsp.ready          = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default pool of 1 MiB
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0000_0000);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0000, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0100, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0040, $urandom);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0000_0100);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0000_0100);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0020, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0020, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0000, $urandom);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0001_2345);
		send_word(ffba_pkg::REQ_ALLOC, 32'h000F_FEC0, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0001, $urandom);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'hFFFF_FFFF);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0000_0120);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0021, $urandom);

		write_pool($urandom_range(1 << 21, 1 << 24));
		repeat (145) random_item(1'b0);

		write_pool(32'h0000_0000);
		send_idle = 58;
		repeat (145) random_item(1'b0);

		write_pool(32'hFFFF_FFFF);
		send_idle  = 0;
		recv_stall = 58;
		repeat (145) random_item(1'b1);

		write_pool(32'h0000_1000);
		send_idle  = 16;
		recv_stall = 16;
		repeat (145) random_item(1'b0);

		// corner words on a full-range pool
		write_pool(32'hFFFF_FFFF);
		send_idle  = 0;
		recv_stall = 0;
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0000, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'h8000_0000, $urandom);
		send_word(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, $urandom);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'h0000_0000);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0000, $urandom);
		send_word(ffba_pkg::REQ_FREE,  $urandom, 32'hFFFF_FFFF);
		send_word(ffba_pkg::REQ_ALLOC, 32'h0000_0010, $urandom);

		wait_replies();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("first_fit_block_allocator: match");
		else
			$display("first_fit_block_allocator: mismatch");
		$finish;
	end

	initial begin
		#100ms;
		$display("first_fit_block_allocator: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ffba_pkg.sv
rtl/ffba_if.sv
rtl/first_fit_block_allocator.sv
tb/ffba_checker.sv
tb/first_fit_block_allocator_test.sv
